>>> design/etur_pkg.sv
// Shared types and constants for the edge-timed serial receiver core.
// No dependencies; imported by etur_div, edge_timed_uart_receiver_core, etur_byte_checker and the testbench.
package etur_pkg;

   localparam int TS_W    = 16;  // capture timestamp and timer period width
   localparam int TPB_W   = 8;   // ticks-per-bit register width
   localparam int CNT_W   = 6;   // bit counter width, also quotient width
   localparam int BYTE_W  = 8;   // shift byte and output byte width
   localparam int WRAP_W  = 8;   // wrap tick counter width
   localparam int CSR_W   = 16;  // configuration write data width
   localparam int CSR_IDX_W = 1; // configuration register index width

   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_BIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_PERIOD  = 1'd1;

   localparam logic [TPB_W-1:0] TPB_RESET    = 8'd10;
   localparam logic [TS_W-1:0]  PERIOD_RESET = 16'd400;

   typedef enum logic [1:0] {
      OP_RISE = 2'd0,
      OP_FALL = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DELTA,
      ST_LOAD,
      ST_DIVIDE,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic              start;
      logic [TS_W-1:0]   delta;
      logic [TPB_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [CNT_W-1:0]  quotient;
   } div_rsp_type;

endpackage

>>> design/etur_div.sv
// Iterative rounded divider: one shared compare/subtract per cycle.
// Depends on etur_pkg (div_req_type, div_rsp_type, widths).
module etur_div
   import etur_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int NUM_W = TS_W + 1;
   localparam int K_W   = $clog2(CNT_W + 1);
   localparam logic [K_W-1:0] K_TOP = K_W'(CNT_W);

   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0] q_ff, q_in;
   logic [TPB_W-1:0] div_ff, div_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [NUM_W-1:0] shifted;
   logic [NUM_W:0]   trial;
   logic             ge;

   // Shared unit: trial subtract of the divisor scaled by 2^k.
   assign shifted = NUM_W'(div_ff) << k_ff;
   assign trial   = {1'b0, rem_ff} - {1'b0, shifted};
   assign ge      = ~trial[NUM_W];

   always_comb begin
      rem_in  = rem_ff;
      k_in    = k_ff;
      q_in    = q_ff;
      div_in  = div_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         // load numerator with the half-divisor rounding term
         rem_in  = NUM_W'(div_req.delta) + NUM_W'(div_req.divisor >> 1);
         div_in  = div_req.divisor;
         k_in    = K_TOP;
         q_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (k_ff == K_TOP) begin
            // top step only checks for saturation
            if (ge) begin
               q_in    = '1;
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               k_in = k_ff - K_W'(1);
            end
         end else begin
            if (ge) begin
               rem_in             = trial[NUM_W-1:0];
               q_in[k_ff]         = 1'b1;
            end
            if (k_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               k_in = k_ff - K_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      k_ff   <= k_in;
      q_ff   <= q_in;
      div_ff <= div_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = q_ff;

endmodule

>>> design/edge_timed_uart_receiver_core.sv
// Edge-timed 8N1 receiver core: an edge of the expected polarity passes through delta,
// load, 1 divider step on saturation or 7 otherwise, the registered divider done and
// apply; ticks, op 3 and unexpected edges go from transfer straight to apply. One item
// is in work at a time. A waiting byte holds the apply step only when the item makes
// another byte.
// Synchronous active-high reset restores 10 ticks per bit, period 400, clears frames.
module edge_timed_uart_receiver_core
   import etur_pkg::*;
#(
   parameter int DATA_BITS = 8
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_op,
   input  logic [TS_W-1:0]      req_timestamp,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_W-1:0]    rsp_byte_data
);

   localparam logic [CNT_W:0]   FRAME_BITS = (CNT_W+1)'(DATA_BITS + 1);
   localparam logic [CNT_W:0]   DATA_TOP   = (CNT_W+1)'(DATA_BITS);
   localparam logic [CNT_W-1:0] CNT_MAX    = '1;

   // configuration registers
   logic [TPB_W-1:0] tpb_ff;
   logic [TS_W-1:0]  period_ff;

   // frame state
   logic [TS_W-1:0]   last_edge_time_ff, last_edge_time_in;
   logic [CNT_W-1:0]  bit_count_ff, bit_count_in;
   logic [BYTE_W-1:0] shift_byte_ff, shift_byte_in;
   logic              expect_rising_ff, expect_rising_in;
   logic [WRAP_W-1:0] wrap_count_ff, wrap_count_in;
   logic [WRAP_W-1:0] wrap_at_last_rise_ff, wrap_at_last_rise_in;

   // captured item
   logic [1:0]        op_ff;
   logic [TS_W-1:0]   ts_ff;
   logic              match_ff;
   logic [TS_W-1:0]   delta_ff, delta_in;

   // result register
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;

   state_type   state_ff, state_in;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic accept, match, slot_free, emit_need, apply_go, apply_fire;
   logic [TPB_W-1:0] divisor;

   etur_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept  = req_valid && !req_stall;
   assign divisor = (tpb_ff == '0) ? TPB_W'(1) : tpb_ff;

   // an edge is taken only when its polarity is the one expected
   always_comb begin
      case (op_type'(req_op))
         OP_RISE: match = expect_rising_ff;
         OP_FALL: match = !expect_rising_ff;
         default: match = 1'b0;
      endcase
   end

   // wrapped edge delta: full period on wrap, floor at zero
   logic [TS_W:0] top;
   always_comb begin
      top = (TS_W+1)'(ts_ff) + (TS_W+1)'(period_ff);
      if (ts_ff > last_edge_time_ff) begin
         delta_in = ts_ff - last_edge_time_ff;
      end else if (top > (TS_W+1)'(last_edge_time_ff)) begin
         delta_in = TS_W'(top - (TS_W+1)'(last_edge_time_ff));
      end else begin
         delta_in = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = match ? ST_DELTA : ST_APPLY;
         end
         ST_DELTA:  state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_rsp.done) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (apply_go) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall       = (state_ff != ST_IDLE);
      div_req.start   = (state_ff == ST_LOAD);
      div_req.delta   = delta_ff;
      div_req.divisor = divisor;
      apply_fire      = (state_ff == ST_APPLY) && apply_go;
   end

   // frame update, evaluated in the apply step
   logic [CNT_W-1:0]  bits;
   logic [CNT_W:0]    sum, base, jpos;
   logic [BYTE_W-1:0] fill_mask, run_mask;
   logic              fill_ok;
   always_comb begin
      bits    = div_rsp.quotient;
      sum     = {1'b0, bit_count_ff} + {1'b0, bits};
      base    = {1'b0, bit_count_ff} - (CNT_W+1)'(1);
      fill_ok = (bit_count_ff != '0) && ({1'b0, bit_count_ff} <= DATA_TOP);
      for (int j = 0; j < BYTE_W; j++) begin
         jpos         = (CNT_W+1)'(j);
         fill_mask[j] = fill_ok && (jpos >= base) && (jpos < DATA_TOP);
         run_mask[j]  = (jpos >= base) && (jpos < base + {1'b0, bits}) &&
                        (jpos < DATA_TOP);
      end

      last_edge_time_in    = last_edge_time_ff;
      bit_count_in         = bit_count_ff;
      shift_byte_in        = shift_byte_ff;
      expect_rising_in     = expect_rising_ff;
      wrap_count_in        = wrap_count_ff;
      wrap_at_last_rise_in = wrap_at_last_rise_ff;
      emit_need            = 1'b0;
      rsp_byte_in          = shift_byte_ff;

      case (op_type'(op_ff))
         OP_RISE: begin
            if (match_ff) begin
               last_edge_time_in    = ts_ff;
               expect_rising_in     = 1'b0;
               wrap_at_last_rise_in = wrap_count_ff;
               bit_count_in         = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
               if (sum == FRAME_BITS) begin
                  emit_need     = 1'b1;
                  bit_count_in  = '0;
                  shift_byte_in = '0;
               end
            end
         end
         OP_FALL: begin
            if (match_ff) begin
               last_edge_time_in = ts_ff;
               expect_rising_in  = 1'b1;
               if (bit_count_ff != '0 && sum > FRAME_BITS) begin
                  // long high run: close the frame with ones
                  emit_need     = 1'b1;
                  rsp_byte_in   = shift_byte_ff | fill_mask;
                  bit_count_in  = '0;
                  shift_byte_in = '0;
               end else if (bit_count_ff != '0) begin
                  shift_byte_in = shift_byte_ff | run_mask;
                  bit_count_in  = sum[CNT_W-1:0];
               end
            end
         end
         OP_TICK: begin
            wrap_count_in = wrap_count_ff + WRAP_W'(1);
            if (wrap_at_last_rise_ff != wrap_count_ff && bit_count_ff != '0) begin
               // timeout: no rising edge since the last tick
               emit_need     = 1'b1;
               rsp_byte_in   = shift_byte_ff | fill_mask;
               bit_count_in  = '0;
               shift_byte_in = '0;
            end
         end
         default: ;
      endcase
   end

   // hold the apply step while a waiting byte has not been taken and the item makes a byte
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign apply_go  = !emit_need || slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_IDLE;
         tpb_ff               <= TPB_RESET;
         period_ff            <= PERIOD_RESET;
         last_edge_time_ff    <= '0;
         bit_count_ff         <= '0;
         shift_byte_ff        <= '0;
         expect_rising_ff     <= 1'b0;
         wrap_count_ff        <= '0;
         wrap_at_last_rise_ff <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_TICKS_PER_BIT: tpb_ff    <= csr_data[TPB_W-1:0];
               CSR_TIMER_PERIOD:  period_ff <= csr_data[TS_W-1:0];
               default: ;
            endcase
         end
         if (apply_fire) begin
            last_edge_time_ff    <= last_edge_time_in;
            bit_count_ff         <= bit_count_in;
            shift_byte_ff        <= shift_byte_in;
            expect_rising_ff     <= expect_rising_in;
            wrap_count_ff        <= wrap_count_in;
            wrap_at_last_rise_ff <= wrap_at_last_rise_in;
         end
         // set on a new byte, drop once the waiting byte transfers
         if (apply_fire && emit_need) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // capture the item on transfer
      if (accept) begin
         op_ff    <= req_op;
         ts_ff    <= req_timestamp;
         match_ff <= match;
      end
      if (state_ff == ST_DELTA) begin
         delta_ff <= delta_in;
      end
      if (apply_fire && emit_need) begin
         rsp_byte_ff <= rsp_byte_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_byte_data = rsp_byte_ff;

   // a transfer always leaves the input side busy for the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input side not busy after transfer");

   // divider completion is only seen while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIVIDE))
      else $error("divider done outside divide step");

   // no bits collect above the configured data width
   assert property (@(posedge clock) disable iff (reset)
      (shift_byte_ff >> DATA_BITS) == '0)
      else $error("shift byte holds bits above data width");

   // a new result only comes out of the apply step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_APPLY))
      else $error("result raised outside apply step");

endmodule

>>> test/etur_byte_checker.sv
// Byte checker for the edge-timed serial receiver core: watches the event and byte
// channels, predicts each byte from the accepted events and compares in order.
// Depends on etur_pkg for op codes, register indexes and widths.
module etur_byte_checker
   import etur_pkg::*;
#(
   parameter int DATA_BITS = 8
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [1:0]           req_op,
   input  logic [TS_W-1:0]      req_timestamp,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [BYTE_W-1:0]    rsp_byte_data,
   output int                   fail_count,
   output int                   pending_bytes
);

   localparam int unsigned FRAME_BITS = DATA_BITS + 1;
   localparam int unsigned DATA_MASK  = (32'd1 << DATA_BITS) - 1;

   // Shadow of the configuration and of the frame state
   logic [TPB_W-1:0]  tpb_reg;
   logic [TS_W-1:0]   period_reg;
   logic [TS_W-1:0]   last_edge_stamp;
   int unsigned       bits_in_frame;
   int unsigned       frame_acc;
   bit                want_rise;
   logic [WRAP_W-1:0] wrap_ticks;
   logic [WRAP_W-1:0] wrap_at_rise;

   logic [BYTE_W-1:0] expected_bytes[$];

   initial fail_count = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t: byte channel mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // Bit times spanned since the previous accepted edge, rounded and capped.
   task automatic measure_run(input logic [TS_W-1:0] stamp, output int unsigned bits);
      int unsigned stamp_u, last_u, divisor, delta, top, quot;
      stamp_u = 32'(stamp);
      last_u  = 32'(last_edge_stamp);
      divisor = (tpb_reg == '0) ? 32'd1 : 32'(tpb_reg);
      if (stamp_u > last_u) begin
         delta = stamp_u - last_u;
      end else begin
         top   = stamp_u + 32'(period_reg);
         delta = (top > last_u) ? top - last_u : 0;
      end
      last_edge_stamp = stamp;
      quot = (delta + divisor / 2) / divisor;
      bits = (quot > 63) ? 63 : quot;
   endtask

   task automatic fill_missing_ones();
      int unsigned n;
      if (bits_in_frame >= 1 && bits_in_frame <= DATA_BITS) begin
         n = FRAME_BITS - bits_in_frame;
         frame_acc = (frame_acc | (((32'd1 << n) - 1) << (bits_in_frame - 1))) & DATA_MASK;
      end
   endtask

   task automatic close_byte(output logic [BYTE_W-1:0] value);
      int unsigned masked;
      masked        = frame_acc & DATA_MASK;
      value         = masked[BYTE_W-1:0];
      bits_in_frame = 0;
      frame_acc     = 0;
   endtask

   task automatic decode_line_event(input logic [1:0] op, input logic [TS_W-1:0] stamp,
                                    output bit made, output logic [BYTE_W-1:0] value);
      int unsigned bits;
      made  = 1'b0;
      value = '0;
      case (op)
         OP_RISE: begin
            if (want_rise) begin
               measure_run(stamp, bits);
               bits_in_frame = bits_in_frame + bits;
               if (bits_in_frame > 63) bits_in_frame = 63;
               wrap_at_rise = wrap_ticks;
               if (bits_in_frame == FRAME_BITS) begin
                  made = 1'b1;
                  close_byte(value);
               end
               want_rise = 1'b0;
            end
         end
         OP_FALL: begin
            if (!want_rise) begin
               measure_run(stamp, bits);
               if (bits_in_frame != 0 && bits_in_frame + bits > FRAME_BITS) begin
                  fill_missing_ones();
                  made = 1'b1;
                  close_byte(value);
               end else if (bits_in_frame != 0) begin
                  frame_acc = (frame_acc | (((32'd1 << bits) - 1) << (bits_in_frame - 1)))
                              & DATA_MASK;
                  bits_in_frame = bits_in_frame + bits;
               end
               want_rise = 1'b1;
            end
         end
         OP_TICK: begin
            if (wrap_at_rise != wrap_ticks && bits_in_frame != 0) begin
               fill_missing_ones();
               made = 1'b1;
               close_byte(value);
            end
            wrap_ticks = wrap_ticks + WRAP_W'(1);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : track
      bit                made;
      logic [BYTE_W-1:0] value;
      logic [BYTE_W-1:0] oldest;
      if (reset) begin
         tpb_reg         = TPB_RESET;
         period_reg      = PERIOD_RESET;
         last_edge_stamp = '0;
         bits_in_frame   = 0;
         frame_acc       = 0;
         want_rise       = 1'b0;
         wrap_ticks      = '0;
         wrap_at_rise    = '0;
         expected_bytes.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_TICKS_PER_BIT) tpb_reg = csr_data[TPB_W-1:0];
            else if (csr_index == CSR_TIMER_PERIOD) period_reg = csr_data[TS_W-1:0];
         end
         // compare before predicting: a byte never leaves on the edge its event enters
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("byte 0x%02h with none expected", rsp_byte_data));
            end else begin
               oldest = expected_bytes.pop_front();
               if (rsp_byte_data !== oldest)
                  report_mismatch($sformatf("byte_data 0x%02h, expected 0x%02h",
                                            rsp_byte_data, oldest));
            end
         end
         if (req_valid && !req_stall) begin
            decode_line_event(req_op, req_timestamp, made, value);
            if (made) expected_bytes.push_back(value);
         end
      end
      pending_bytes = expected_bytes.size();
   end

endmodule

>>> test/edge_timed_uart_receiver_core_tb.sv
// Testbench top for edge_timed_uart_receiver_core: builds serial frames as timed
// line edges and wrap ticks, drives both channels with random idling and judges.
// Depends on etur_pkg, the core and etur_byte_checker.
module edge_timed_uart_receiver_core_tb
   import etur_pkg::*;
;

   localparam int DATA_BITS        = 8;
   localparam int PHASES           = 8;
   localparam int RANDOM_PER_PHASE = 240;
   localparam int SETTLE_CYCLES    = 16;    // lets the core finish an item that makes no byte
   localparam int HOLD_CYCLES      = 400;   // receiver hold-off that backs up the input
   localparam int WATCHDOG_LIMIT   = 4000;  // cycles with no transfer on either side
   localparam logic [1:0] OP_SPARE = 2'd3;  // unused op code, ignored by the core

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TICKS_PER_BIT;
   logic [CSR_W-1:0]     csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_op = OP_TICK;
   logic [TS_W-1:0]      req_timestamp = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [BYTE_W-1:0]    rsp_byte_data;

   int fail_count;
   int pending_bytes;

   // Stimulus state: the line runs on a virtual tick time that wraps every period
   int     cur_tpb;
   int     cur_period;
   longint line_time;
   longint next_wrap;
   int     items_sent = 0;

   // Receiver state
   int hold_asked = 0;
   int hold_taken = 0;
   int hold_left  = 0;
   int run_left   = 0;
   bit stalling   = 1'b0;
   int quiet_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   edge_timed_uart_receiver_core #(
      .DATA_BITS(DATA_BITS)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_timestamp (req_timestamp),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_byte_data (rsp_byte_data)
   );

   etur_byte_checker #(
      .DATA_BITS(DATA_BITS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_timestamp (req_timestamp),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_byte_data (rsp_byte_data),
      .fail_count    (fail_count),
      .pending_bytes (pending_bytes)
   );

   // Idle length in cycles: mostly none or short, now and then a long one.
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Line idle time after a stop bit, in timer ticks; the longest ones span
   // up to three wraps so that the timeout path fires.
   function automatic longint idle_span(input int bt);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return longint'($urandom_range(0, 2 * bt));
      if (pick < 85) return longint'($urandom_range(2 * bt, 12 * bt));
      return longint'($urandom_range(cur_period, 3 * cur_period));
   endfunction

   // Offer one event after a random gap and hold it until the core takes it.
   // Valid is lowered only when a gap is taken, so a back-to-back transfer
   // keeps valid high with a single assignment at that falling edge.
   task automatic send_item(input logic [1:0] op, input logic [TS_W-1:0] stamp);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_op        <= op;
      req_timestamp <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op != OP_SPARE) items_sent++;
   endtask

   // Emit the wrap ticks that fall before the edge, then the edge itself with
   // its timestamp taken modulo the timer period.
   task automatic line_edge(input logic [1:0] op, input longint at);
      logic [TS_W-1:0] stamp;
      while (next_wrap <= at) begin
         send_item(OP_TICK, TS_W'($urandom_range(0, 65535)));
         next_wrap += cur_period;
      end
      stamp = TS_W'(at % cur_period);
      send_item(op, stamp);
   endtask

   // One 8N1 frame, LSB first, as the edges between differing bits. Jitter
   // stays within a sixth of a bit so the edges keep their order. A skip index
   // drops one edge to mimic a missed transition.
   task automatic send_frame(input logic [7:0] data, input int skip);
      int     bt, jit, edge_no;
      bit     lvl, nxt;
      longint t;
      bt      = (cur_tpb == 0) ? 1 : cur_tpb;
      t       = line_time;
      lvl     = 1'b1;
      edge_no = 0;
      for (int i = 0; i < 10; i++) begin
         nxt = (i == 0) ? 1'b0 : (i == 9) ? 1'b1 : data[i-1];
         if (nxt != lvl) begin
            jit = int'($urandom_range(0, bt / 3)) - bt / 6;
            if (edge_no != skip) line_edge(nxt ? OP_RISE : OP_FALL, t + jit);
            edge_no++;
            lvl = nxt;
         end
         t += bt;
      end
      line_time = t + idle_span(bt);
   endtask

   // Mostly clean frames with random bytes, some with a dropped edge, and
   // bursts of raw events with any op and any timestamp.
   task automatic random_traffic(input int target);
      int pick;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 75)
            send_frame(8'($urandom_range(0, 255)), -1);
         else if (pick < 87)
            send_frame(8'($urandom_range(0, 255)), int'($urandom_range(0, 4)));
         else
            repeat ($urandom_range(1, 4))
               send_item(2'($urandom_range(0, 3)), TS_W'($urandom_range(0, 65535)));
      end
   endtask

   // Drop valid, wait for every expected byte, then let the core finish any
   // event that produces no byte.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_bytes != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Raise the write enable with index and data; the caller lowers it after
   // the last write so back-to-back writes never toggle it within a step.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
   endtask

   // Receiver: alternate stall and free runs of random length, and serve a
   // requested hold-off by stalling for a fixed count of cycles.
   always @(negedge clock) begin
      if (hold_left == 0 && hold_taken != hold_asked) begin
         hold_taken = hold_asked;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (run_left == 0) begin
            stalling = !stalling;
            if (stalling)
               run_left = gap_length();
            else if ($urandom_range(0, 9) == 0)
               run_left = $urandom_range(40, 160);
            else
               run_left = gap_length() + 1;
         end
         if (run_left == 0) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= stalling;
            run_left--;
         end
      end
   end

   // Watchdog: end the run when neither channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("edge_timed_uart_receiver_core verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      cur_tpb    = int'(TPB_RESET);
      cur_period = int'(PERIOD_RESET);

      // Directed events at reset settings (10 ticks per bit, period 400)
      send_item(OP_FALL, 16'd0);      // idle frame: start edge only takes the time
      send_item(OP_FALL, 16'd5);      // wrong polarity: ignored, time kept
      send_item(OP_RISE, 16'd90);     // nine zero bits: byte of zeros
      send_item(OP_FALL, 16'd100);
      send_item(OP_RISE, 16'd120);    // start plus one zero
      send_item(OP_FALL, 16'd150);    // three ones
      send_item(OP_RISE, 16'd165);    // rounds 1.5 bits up
      send_item(OP_FALL, 16'd184);    // lands exactly on the frame length
      send_item(OP_RISE, 16'd190);    // runs past the frame: no byte yet
      send_item(OP_FALL, 16'd399);    // long high run with count already full
      send_item(OP_RISE, 16'd20);     // timer wrapped between edges
      send_item(OP_FALL, 16'd40);
      send_item(OP_TICK, 16'd0);      // rising edge seen this wrap: hold
      send_item(OP_TICK, 16'hFFFF);   // no rising edge since: timeout fills ones
      send_item(OP_FALL, 16'hFFFF);   // a rise is expected: ignored, time kept
      send_item(OP_RISE, 16'd3);      // timer wrapped: long zero run, count past the frame
      send_item(OP_FALL, 16'd10);
      send_item(OP_RISE, 16'd1000);   // stamp past the period, count saturates
      send_item(OP_FALL, 16'd1005);
      send_item(OP_SPARE, 16'hFFFF);  // unused op: nothing happens
      send_item(OP_SPARE, 16'd0);
      send_item(OP_RISE, 16'd1010);
      send_item(OP_FALL, 16'd1100);   // long high run fills all data bits

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            settle();
            case (phase)
               1: begin cur_tpb = 2;   cur_period = 16;    end
               2: begin cur_tpb = 255; cur_period = 65535; end
               3: begin cur_tpb = 0;   cur_period = 40;    end  // zero bit time acts as one
               default: begin
                  cur_tpb    = $urandom_range(2, 60);
                  cur_period = $urandom_range(cur_tpb * 12, cur_tpb * 12 + 3000);
               end
            endcase
            write_csr(CSR_TICKS_PER_BIT, CSR_W'(cur_tpb));
            write_csr(CSR_TIMER_PERIOD, CSR_W'(cur_period));
            @(negedge clock);
            csr_wr_en <= 1'b0;
         end
         line_time = 64;
         next_wrap = line_time + cur_period;
         // back up the core behind a long receiver hold-off in two phases
         if (phase == 0 || phase == 4) hold_asked++;
         random_traffic(items_sent + RANDOM_PER_PHASE);
      end

      settle();
      if (fail_count == 0)
         $display("edge_timed_uart_receiver_core verification clean");
      else
         $display("edge_timed_uart_receiver_core verification failed");
      $finish;
   end

endmodule

>>> edge_timed_uart_receiver_core.f
design/etur_pkg.sv
design/etur_div.sv
design/edge_timed_uart_receiver_core.sv
test/etur_byte_checker.sv
test/edge_timed_uart_receiver_core_tb.sv
